/* sv/dfa_pkg.sv */
// shared constants, types and helpers for the table driven dfa recognizer
`default_nettype none

package dfa_pkg;

	// automaton size
	localparam int STATES   = 128;
	localparam int SYMBOLS  = 64;
	localparam int ST_W     = $clog2(STATES);
	localparam int SYM_W    = $clog2(SYMBOLS);
	localparam int TT_DEPTH = STATES * SYMBOLS;
	localparam int TT_AW    = $clog2(TT_DEPTH);

	// fixed port widths
	localparam int FUNC_W   = 3;
	localparam int SYM_IN_W = 6;
	localparam int ST_IN_W  = 8;
	localparam int CHAR_W   = 8;
	localparam int START_W  = 8;
	localparam int ASIZE_W  = 7;
	localparam int FINAL_W  = 8;
	localparam int CFG_IW   = 1;
	localparam int CFG_DW   = 8;

	// input function codes
	localparam logic [FUNC_W-1:0] FUNC_WR_SYM    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_WR_TRANS  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_WR_ACCEPT = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_FEED      = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_END       = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] CFG_START = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_ASIZE = 1'b1;

	// operations handed from front to back
	localparam logic [1:0] OP_TRANS  = 2'd0;
	localparam logic [1:0] OP_ACCEPT = 2'd1;
	localparam logic [1:0] OP_FEED   = 2'd2;
	localparam logic [1:0] OP_END    = 2'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [ST_W-1:0]  st;
		logic [SYM_W-1:0] sym;
		logic [ST_W-1:0]  nxt;
		logic             flag;
		logic             found;
		logic             last;
	} op_t;

	typedef struct packed {
		logic               accepted;
		logic               bad_symbol;
		logic [FINAL_W-1:0] final_state;
	} res_t;

	// queue handshake between front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// flat transition table address of a state and symbol index
	function automatic logic [TT_AW-1:0] tt_addr(input logic [ST_W-1:0] s,
		input logic [SYM_W-1:0] y);
		return TT_AW'(TT_AW'(s) * TT_AW'(SYMBOLS)) + TT_AW'(y);
	endfunction

endpackage

`default_nettype wire

/* sv/table_driven_dfa_recognizer_unit.sv */
// top level of the table driven dfa string recognizer
//
// channel   direction  handshake                       payload
// input     in         push / full                     func .. last_char
// result    out        empty / pop                     accepted, bad_symbol, final_state
// config    in         cfg_we, no wait                 cfg_index, cfg_wdata
//
// a feed item holds the back part in its wait state (registered transition ram
// read); the back takes no new item until that feed completes.
// a queued item passes the input stage, a 2-entry operation queue and the back part.
// reset clears control state and accept marks at once; no clearing pass.
// full rises while the staged item needs the operation queue and that queue is
// full; the back stalls while the 2-entry result queue has no room.
`default_nettype none

module table_driven_dfa_recognizer_unit (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	output logic                         full,
	input  wire [dfa_pkg::FUNC_W-1:0]    func,
	input  wire [dfa_pkg::SYM_IN_W-1:0]  symbol_index,
	input  wire [dfa_pkg::ST_IN_W-1:0]   state_index,
	input  wire [dfa_pkg::CHAR_W-1:0]    char_value,
	input  wire [dfa_pkg::ST_IN_W-1:0]   next_state,
	input  wire                          accept_flag,
	input  wire                          last_char,
	output logic                         empty,
	input  wire                          pop,
	output logic                         accepted,
	output logic                         bad_symbol,
	output logic [dfa_pkg::FINAL_W-1:0]  final_state,
	input  wire                          cfg_we,
	input  wire [dfa_pkg::CFG_IW-1:0]    cfg_index,
	input  wire [dfa_pkg::CFG_DW-1:0]    cfg_wdata
);
	import dfa_pkg::*;

	logic [START_W-1:0] start_q;
	logic [ASIZE_W-1:0] asize_q;
	q_stat_t            q_stat;
	logic               q_push, q_pop;
	op_t                q_wr_op, q_rd_op;
	res_t               res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_W'(1);
			asize_q <= ASIZE_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == CFG_START) begin
				start_q <= START_W'(cfg_wdata);
			end
			if (cfg_index == CFG_ASIZE) begin
				asize_q <= ASIZE_W'(cfg_wdata);
			end
		end
	end

	dfa_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.func          (func),
		.symbol_index  (symbol_index),
		.state_index   (state_index),
		.char_value    (char_value),
		.next_state    (next_state),
		.accept_flag   (accept_flag),
		.last_char     (last_char),
		.sym_count     (asize_q),
		.q_stat        (q_stat),
		.q_push        (q_push),
		.q_op          (q_wr_op)
	);

	dfa_op_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wr_op  (q_wr_op),
		.rd     (q_pop),
		.rd_op  (q_rd_op),
		.stat   (q_stat)
	);

	dfa_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.q_op        (q_rd_op),
		.q_pop       (q_pop),
		.init_state  (start_q),
		.pop         (pop),
		.empty       (empty),
		.res         (res)
	);

	assign accepted    = res.accepted;
	assign bad_symbol  = res.bad_symbol;
	assign final_state = res.final_state;

endmodule

`default_nettype wire

/* sv/dfa_front.sv */
// front part: input stage, symbol table, parallel symbol search, classification
`default_nettype none

module dfa_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          push,
	output logic                         full,
	input  wire [dfa_pkg::FUNC_W-1:0]    func,
	input  wire [dfa_pkg::SYM_IN_W-1:0]  symbol_index,
	input  wire [dfa_pkg::ST_IN_W-1:0]   state_index,
	input  wire [dfa_pkg::CHAR_W-1:0]    char_value,
	input  wire [dfa_pkg::ST_IN_W-1:0]   next_state,
	input  wire                          accept_flag,
	input  wire                          last_char,
	input  wire [dfa_pkg::ASIZE_W-1:0]   sym_count,
	input  dfa_pkg::q_stat_t             q_stat,
	output logic                         q_push,
	output dfa_pkg::op_t                 q_op
);
	import dfa_pkg::*;

	logic                s1_valid_q;
	logic [FUNC_W-1:0]   func_s1;
	logic [SYM_IN_W-1:0] sym_s1;
	logic [ST_IN_W-1:0]  st_s1;
	logic [CHAR_W-1:0]   ch_s1;
	logic [ST_IN_W-1:0]  nx_s1;
	logic                flag_s1;
	logic                last_s1;

	logic [CHAR_W-1:0]   sym_tab_q [SYMBOLS];

	logic                accept_in;
	logic                need_q;
	logic                retire;
	logic                st_ok, nx_ok, sym_ok;
	logic [15:0]         st16, nx16, n16;
	logic [SYMBOLS-1:0]  match;
	logic                hit;
	logic [SYM_W-1:0]    hit_idx;

	assign accept_in = push && !full;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept_in) begin
			s1_valid_q <= 1'b1;
		end else if (retire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			func_s1 <= func;
			sym_s1  <= symbol_index;
			st_s1   <= state_index;
			ch_s1   <= char_value;
			nx_s1   <= next_state;
			flag_s1 <= accept_flag;
			last_s1 <= last_char;
		end
	end

	// index range checks
	always_comb begin
		st16   = 16'(st_s1);
		nx16   = 16'(nx_s1);
		st_ok  = (st16 >= 16'd1) && (st16 <= 16'(STATES));
		nx_ok  = (nx16 >= 16'd1) && (nx16 <= 16'(STATES));
		sym_ok = 16'(sym_s1) < 16'(SYMBOLS);
	end

	// parallel compare against the symbols in use, lowest index wins
	always_comb begin
		n16 = (16'(sym_count) > 16'(SYMBOLS)) ? 16'(SYMBOLS) : 16'(sym_count);
		for (int i = 0; i < SYMBOLS; i++) begin
			match[i] = (sym_tab_q[i] == ch_s1) && (16'(i) < n16);
		end
		hit     = |match;
		hit_idx = '0;
		for (int i = SYMBOLS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = SYM_W'(i);
			end
		end
	end

	// classify the staged item into a back-end operation
	always_comb begin
		need_q     = 1'b0;
		q_op.kind  = OP_END;
		q_op.st    = ST_W'(st16 - 16'd1);
		q_op.sym   = SYM_W'(sym_s1);
		q_op.nxt   = ST_W'(nx16 - 16'd1);
		q_op.flag  = flag_s1;
		q_op.found = hit;
		q_op.last  = last_s1;
		unique case (func_s1)
			FUNC_WR_SYM: begin
				need_q = 1'b0;
			end
			FUNC_WR_TRANS: begin
				need_q    = sym_ok && st_ok && nx_ok;
				q_op.kind = OP_TRANS;
			end
			FUNC_WR_ACCEPT: begin
				need_q    = st_ok;
				q_op.kind = OP_ACCEPT;
			end
			FUNC_FEED: begin
				need_q    = 1'b1;
				q_op.kind = OP_FEED;
				q_op.sym  = hit_idx;
			end
			FUNC_END: begin
				need_q    = 1'b1;
				q_op.kind = OP_END;
			end
			default: begin
				need_q = 1'b0;
			end
		endcase
	end

	assign retire = !need_q || !q_stat.full;
	assign full   = s1_valid_q && !retire;
	assign q_push = s1_valid_q && need_q && !q_stat.full;

	// symbol table write, done in order with the search
	always_ff @(posedge clk) begin
		if (s1_valid_q && (func_s1 == FUNC_WR_SYM) && sym_ok) begin
			sym_tab_q[SYM_W'(sym_s1)] <= ch_s1;
		end
	end

endmodule

`default_nettype wire

/* sv/dfa_op_queue.sv */
// two-entry queue of classified operations between front and back
`default_nettype none

module dfa_op_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               wr,
	input  dfa_pkg::op_t      wr_op,
	input  wire               rd,
	output dfa_pkg::op_t      rd_op,
	output dfa_pkg::q_stat_t  stat
);
	import dfa_pkg::*;

	op_t        ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign rd_op      = ent_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wp_q <= !wp_q;
			end
			if (do_rd) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wp_q] <= wr_op;
		end
	end

endmodule

`default_nettype wire

/* sv/dfa_back.sv */
// back part: transition ram, accept marks, current state and result queue
`default_nettype none

module dfa_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  dfa_pkg::q_stat_t             q_stat,
	input  dfa_pkg::op_t                 q_op,
	output logic                         q_pop,
	input  wire [dfa_pkg::START_W-1:0]   init_state,
	input  wire                          pop,
	output logic                         empty,
	output dfa_pkg::res_t                res
);
	import dfa_pkg::*;

	localparam logic B_IDLE = 1'b0;
	localparam logic B_WAIT = 1'b1;

	logic             bstate_q;
	op_t              cur_q;
	logic [ST_W-1:0]  cs_q;
	logic             rej_q;
	logic [STATES-1:0] marks_q;

	logic [ST_W-1:0]  tt_mem [TT_DEPTH];
	logic [ST_W-1:0]  tt_rd_q;

	res_t             rq_q [2];
	logic             rq_wp_q, rq_rp_q;
	logic [1:0]       rq_cnt_q;

	logic             take;
	logic             tt_we, tt_re;
	logic [TT_AW-1:0] tt_waddr, tt_raddr;
	logic [15:0]      s16;
	logic [ST_W-1:0]  start_idx;
	logic [ST_W-1:0]  feed_cs, fin_cs;
	logic             feed_rej, fin_rej;
	logic             fin;
	res_t             fin_res;
	logic             rq_rd;

	// take an operation only with room for a possible result
	assign take  = (bstate_q == B_IDLE) && !q_stat.empty && (rq_cnt_q != 2'd2);
	assign q_pop = take;

	// clamped start state index
	always_comb begin
		s16 = 16'(init_state);
		if (s16 == 16'd0) begin
			s16 = 16'd1;
		end
		if (s16 > 16'(STATES)) begin
			s16 = 16'(STATES);
		end
		start_idx = ST_W'(s16 - 16'd1);
	end

	// transition ram ports
	always_comb begin
		tt_we    = take && (q_op.kind == OP_TRANS);
		tt_waddr = tt_addr(q_op.st, q_op.sym);
		tt_re    = take && (q_op.kind == OP_FEED) && q_op.found && !rej_q;
		tt_raddr = tt_addr(cs_q, q_op.sym);
	end

	always_ff @(posedge clk) begin
		if (tt_we) begin
			tt_mem[tt_waddr] <= q_op.nxt;
		end
		if (tt_re) begin
			tt_rd_q <= tt_mem[tt_raddr];
		end
	end

	// feed completion and string end
	always_comb begin
		feed_cs  = cs_q;
		feed_rej = rej_q;
		if (!rej_q && cur_q.found) begin
			feed_cs = (32'(tt_rd_q) >= STATES) ? '0 : tt_rd_q;
		end else if (!rej_q) begin
			feed_rej = 1'b1;
		end
		fin     = ((bstate_q == B_WAIT) && cur_q.last) || (take && (q_op.kind == OP_END));
		fin_cs  = (bstate_q == B_WAIT) ? feed_cs : cs_q;
		fin_rej = (bstate_q == B_WAIT) ? feed_rej : rej_q;
		fin_res.accepted    = !fin_rej && marks_q[fin_cs];
		fin_res.bad_symbol  = fin_rej;
		fin_res.final_state = FINAL_W'(fin_cs) + FINAL_W'(1);
	end

	// sequencer, current state and sticky reject
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bstate_q <= B_IDLE;
			cs_q     <= '0;
			rej_q    <= 1'b0;
		end else begin
			unique case (bstate_q)
				B_IDLE: begin
					if (take && (q_op.kind == OP_FEED)) begin
						bstate_q <= B_WAIT;
					end
				end
				B_WAIT: begin
					bstate_q <= B_IDLE;
				end
				default: begin
					bstate_q <= B_IDLE;
				end
			endcase
			if (fin) begin
				cs_q  <= start_idx;
				rej_q <= 1'b0;
			end else if (bstate_q == B_WAIT) begin
				cs_q  <= feed_cs;
				rej_q <= feed_rej;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= q_op;
		end
	end

	// accept marks, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q <= '0;
		end else if (take && (q_op.kind == OP_ACCEPT)) begin
			marks_q[q_op.st] <= q_op.flag;
		end
	end

	// result queue
	assign empty = (rq_cnt_q == 2'd0);
	assign rq_rd = pop && !empty;
	assign res   = rq_q[rq_rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wp_q  <= 1'b0;
			rq_rp_q  <= 1'b0;
			rq_cnt_q <= 2'd0;
		end else begin
			if (fin) begin
				rq_wp_q <= !rq_wp_q;
			end
			if (rq_rd) begin
				rq_rp_q <= !rq_rp_q;
			end
			rq_cnt_q <= rq_cnt_q + 2'(fin) - 2'(rq_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			rq_q[rq_wp_q] <= fin_res;
		end
	end

endmodule

`default_nettype wire

/* sv/dfa_checker.sv */
// port-level checker for the dfa recognizer and its bind
`default_nettype none

module dfa_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          full,
	input wire                          empty,
	input wire                          pop,
	input wire                          accepted,
	input wire                          bad_symbol,
	input wire [dfa_pkg::FINAL_W-1:0]   final_state
);
	import dfa_pkg::*;

	// a waiting result holds until its transaction completes
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(accepted) && $stable(bad_symbol)
			&& $stable(final_state)))
		else $error("result changed while stalled");

	// a string with a bad symbol is never accepted
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && accepted) |-> !bad_symbol)
		else $error("accepted together with bad symbol");

	// final state lies in the state range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((final_state != '0) && (32'(final_state) <= STATES)))
		else $error("final state out of range");

	// both queues come out of reset empty
	a_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> (empty && !full))
		else $error("queues not empty after reset");

endmodule

bind table_driven_dfa_recognizer_unit dfa_checker u_dfa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.accepted    (accepted),
	.bad_symbol  (bad_symbol),
	.final_state (final_state)
);

`default_nettype wire
